@@ sv/lkd_pkg.sv @@
// Shared types, codes and sizes for the keyed-delete candidate stack.
// Used by lkd_ctrl, lkd_dp and lifo_with_keyed_delete_core; no dependencies.
package lkd_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int HANDLE_BITS = 8;
    localparam int GUID_W      = 32;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What the result register is loaded with.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_FULL,
        RES_POP_EMPTY,
        RES_POP_DATA,
        RES_FOUND
    } res_kind_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_PTR,
        RD_PTR_UP
    } rd_sel_t;

    typedef enum logic {
        WR_INPUT,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic [GUID_W-1:0]      guid_first;
        logic [GUID_W-1:0]      guid_second;
        logic [HANDLE_BITS-1:0] owner;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic      capture_in;
        logic      mem_rd;
        rd_sel_t   rd_sel;
        logic      mem_wr;
        wr_sel_t   wr_sel;
        logic      ptr_load_top;
        logic      ptr_inc;
        logic      ptr_dec;
        logic      count_inc;
        logic      count_dec;
        res_kind_t res_kind;
        logic      load_out;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        action_t act;
        logic    full;
        logic    empty;
        logic    match;
        logic    ptr_zero;
        logic    ptr_last;
        logic    ptr_next_last;
    } dp_stat_t;

endpackage

@@ sv/lkd_ctrl.sv @@
// Sequencing state machine of the candidate stack: decodes the action,
// walks the search and gap-closing loops and owns the result beat valid.
// Depends on lkd_pkg.
module lkd_ctrl
    import lkd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_DATA,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_TOP;
        cmd.wr_sel     = WR_INPUT;
        cmd.res_kind   = RES_NONE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESP;
                unique case (stat.act)
                    ACT_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_kind = RES_FULL;
                        end
                        else
                        begin
                            cmd.mem_wr    = 1'b1;
                            cmd.wr_sel    = WR_INPUT;
                            cmd.count_inc = 1'b1;
                            cmd.res_kind  = RES_OK;
                        end
                    end
                    ACT_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_kind = RES_POP_EMPTY;
                        end
                        else
                        begin
                            cmd.mem_rd    = 1'b1;
                            cmd.rd_sel    = RD_TOP;
                            cmd.count_dec = 1'b1;
                            state_next    = S_POP_DATA;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_kind = RES_OK;
                        end
                        else
                        begin
                            cmd.ptr_load_top = 1'b1;
                            state_next       = S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        cmd.res_kind = RES_OK;
                    end
                endcase
            end
            S_POP_DATA:
            begin
                cmd.res_kind = RES_POP_DATA;
                state_next   = S_RESP;
            end
            S_SRCH_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_PTR;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    if (stat.ptr_last)
                    begin
                        cmd.count_dec = 1'b1;
                        cmd.res_kind  = RES_FOUND;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (stat.ptr_zero)
                begin
                    cmd.res_kind = RES_OK;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SH_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_PTR_UP;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.ptr_inc = 1'b1;
                if (stat.ptr_next_last)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.res_kind  = RES_FOUND;
                    state_next    = S_RESP;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/lkd_dp.sv @@
// Datapath of the candidate stack: entry memory, occupancy count, scan
// pointer, captured request, result staging and the result beat register.
// Depends on lkd_pkg.
module lkd_dp
    import lkd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [ACT_W-1:0]       action,
    input  logic [GUID_W-1:0]      guid_first,
    input  logic [GUID_W-1:0]      guid_second,
    input  logic [HANDLE_BITS-1:0] owner_handle,
    output logic                   found,
    output logic [GUID_W-1:0]      out_guid_first,
    output logic [GUID_W-1:0]      out_guid_second,
    output logic [HANDLE_BITS-1:0] out_owner_handle,
    output logic [STAT_W-1:0]      status,
    output logic [CNT_W-1:0]       occupancy
);

    entry_t mem [LIST_DEPTH];

    action_t                act_reg;
    entry_t                 req_reg;
    entry_t                 rd_data_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    entry_t                 wr_data;
    logic [CNT_W-1:0]       ptr_plus1, ptr_plus2;

    logic                   res_found_reg;
    logic [GUID_W-1:0]      res_g1_reg, res_g2_reg;
    logic [HANDLE_BITS-1:0] res_h_reg;
    status_t                res_status_reg;

    logic                   out_found_reg;
    logic [GUID_W-1:0]      out_g1_reg, out_g2_reg;
    logic [HANDLE_BITS-1:0] out_h_reg;
    logic [STAT_W-1:0]      out_status_reg;
    logic [CNT_W-1:0]       out_occ_reg;

    assign ptr_plus1 = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_plus2 = CNT_W'(ptr_reg) + CNT_W'(2);

    assign stat.act           = act_reg;
    assign stat.full          = (count_reg == CNT_W'(LIST_DEPTH));
    assign stat.empty         = (count_reg == '0);
    assign stat.match         = (rd_data_reg == req_reg);
    assign stat.ptr_zero      = (ptr_reg == '0);
    assign stat.ptr_last      = (ptr_plus1 == count_reg);
    assign stat.ptr_next_last = (ptr_plus2 == count_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_TOP:    rd_addr = IDX_W'(count_reg - CNT_W'(1));
            RD_PTR:    rd_addr = ptr_reg;
            RD_PTR_UP: rd_addr = IDX_W'(ptr_plus1);
            default:   rd_addr = ptr_reg;
        endcase
        unique case (cmd.wr_sel)
            WR_INPUT:
            begin
                wr_addr = IDX_W'(count_reg);
                wr_data = req_reg;
            end
            WR_SHIFT:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.ptr_load_top)
        begin
            ptr_next = IDX_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + IDX_W'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.capture_in)
        begin
            act_reg             <= action_t'(action);
            req_reg.guid_first  <= guid_first;
            req_reg.guid_second <= guid_second;
            req_reg.owner       <= owner_handle;
        end
    end

    // Result staging: fields are built as the step finishes.
    always_ff @(posedge clk)
    begin
        unique case (cmd.res_kind)
            RES_NONE:
            begin
            end
            RES_OK, RES_FULL:
            begin
                res_found_reg  <= 1'b0;
                res_g1_reg     <= '0;
                res_g2_reg     <= '0;
                res_h_reg      <= '0;
                res_status_reg <= (cmd.res_kind == RES_FULL) ? ST_FULL : ST_OK;
            end
            RES_POP_EMPTY:
            begin
                res_found_reg  <= 1'b0;
                res_g1_reg     <= '1;
                res_g2_reg     <= '1;
                res_h_reg      <= '0;
                res_status_reg <= ST_EMPTY;
            end
            RES_POP_DATA:
            begin
                res_found_reg  <= 1'b1;
                res_g1_reg     <= rd_data_reg.guid_first;
                res_g2_reg     <= rd_data_reg.guid_second;
                res_h_reg      <= rd_data_reg.owner;
                res_status_reg <= ST_OK;
            end
            RES_FOUND:
            begin
                res_found_reg  <= 1'b1;
                res_g1_reg     <= '0;
                res_g2_reg     <= '0;
                res_h_reg      <= '0;
                res_status_reg <= ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg  <= res_found_reg;
            out_g1_reg     <= res_g1_reg;
            out_g2_reg     <= res_g2_reg;
            out_h_reg      <= res_h_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= count_reg;
        end
    end

    assign found            = out_found_reg;
    assign out_guid_first   = out_g1_reg;
    assign out_guid_second  = out_g2_reg;
    assign out_owner_handle = out_h_reg;
    assign status           = out_status_reg;
    assign occupancy        = out_occ_reg;

endmodule

@@ sv/lifo_with_keyed_delete_core.sv @@
// Top level of the bounded candidate stack with delete by key.
// Instantiates lkd_ctrl and lkd_dp; depends on lkd_pkg.
//
//  Channel   Direction  Handshake            Beat contents
//  in        sink       in_valid/in_ready    action, guid_first, guid_second, owner_handle
//  out       source     out_valid/out_ready  found, out_guid_first, out_guid_second,
//                                            out_owner_handle, status, occupancy
//
// One request is worked on at a time. A push, a refused push, a pop of an
// empty list, a removal from an empty list or the no-operation code passes
// through the dispatch state to the response state; a pop with data also
// passes through a read state. A removal scans the entries from the top
// down, each comparison waiting on the registered read of the single entry
// memory, and then closes the gap by reading and rewriting each moved entry
// in turn. The core is ready for the next request beat in the cycle in which
// the result beat appears.
// Reset empties the list at once; the entry memory itself is never cleared,
// as only entries below the occupancy count are ever read.
// A new request is taken while an earlier result beat still waits in the
// output register; only the finishing step of that request stalls on it.
module lifo_with_keyed_delete_core
    import lkd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ACT_W-1:0]       action,
    input  logic [GUID_W-1:0]      guid_first,
    input  logic [GUID_W-1:0]      guid_second,
    input  logic [HANDLE_BITS-1:0] owner_handle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [GUID_W-1:0]      out_guid_first,
    output logic [GUID_W-1:0]      out_guid_second,
    output logic [HANDLE_BITS-1:0] out_owner_handle,
    output logic [STAT_W-1:0]      status,
    output logic [CNT_W-1:0]       occupancy
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller decides every step; the datapath only obeys commands
    // and reports the few flags the sequencing needs.
    lkd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lkd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .action           (action),
        .guid_first       (guid_first),
        .guid_second      (guid_second),
        .owner_handle     (owner_handle),
        .found            (found),
        .out_guid_first   (out_guid_first),
        .out_guid_second  (out_guid_second),
        .out_owner_handle (out_owner_handle),
        .status           (status),
        .occupancy        (occupancy)
    );

    // The list can never report more entries than it has slots.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CNT_W'(LIST_DEPTH)))
        else $error("occupancy beyond list depth");

    // A refused push happens only on a full list and never reports a hit.
    a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |->
            (!found && (occupancy == CNT_W'(LIST_DEPTH))))
        else $error("refused push with wrong fields");

    // A pop on an empty list leaves it empty and returns the all-ones key.
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |->
            (!found && (occupancy == '0) && (out_guid_first == '1)
             && (out_guid_second == '1)))
        else $error("empty pop with wrong fields");

    // A hit is always reported with a good status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK))
        else $error("hit reported with error status");

    // Requests are only taken while the previous one has been fully handed on
    // to the output register or is not under way at all.
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

endmodule
